>>> rtl/core/hpbp_pkg.sv
// ----------------------------------------------------------------------------
// hpbp_pkg: shared types and codes for the hpack header block parser
// Token and field codes, the queue item and the result token layout.
// ----------------------------------------------------------------------------
package hpbp_pkg;

  localparam int VALUE_W = 32;
  localparam int QDEPTH  = 4;
  localparam int QAW     = $clog2(QDEPTH);

  // token kinds
  localparam logic [1:0] TK_START    = 2'd0;
  localparam logic [1:0] TK_STR_HDR  = 2'd1;
  localparam logic [1:0] TK_STR_BYTE = 2'd2;
  localparam logic [1:0] TK_ERROR    = 2'd3;

  // field kinds
  localparam logic [2:0] FK_INDEXED = 3'd0;
  localparam logic [2:0] FK_INC_IDX = 3'd1;
  localparam logic [2:0] FK_NO_IDX  = 3'd2;
  localparam logic [2:0] FK_NEVER   = 3'd3;
  localparam logic [2:0] FK_SIZE    = 3'd4;

  // error codes
  localparam logic ERR_OVERFLOW   = 1'b0;
  localparam logic ERR_ZERO_INDEX = 1'b1;

  // parse phases
  localparam logic [2:0] PH_FIRST     = 3'd0;
  localparam logic [2:0] PH_FIELD_INT = 3'd1;
  localparam logic [2:0] PH_STR_HDR   = 3'd2;
  localparam logic [2:0] PH_STR_INT   = 3'd3;
  localparam logic [2:0] PH_STR_BYTES = 3'd4;

  localparam logic [2:0] CONT_MAX = 3'd7;
  localparam logic [6:0] PFX7_ONES = 7'h7f;

  // octet plus its decode as if it opened a field representation
  typedef struct packed {
    logic [7:0] octet;
    logic [2:0] kind;
    logic [6:0] prefix_val;
    logic       prefix_full;
  } hpbp_item_t;

  typedef struct packed {
    logic [1:0]         token_kind;
    logic [2:0]         field_kind;
    logic [VALUE_W-1:0] number;
    logic [7:0]         string_byte;
    logic               is_value;
    logic               huffman_coded;
    logic               last_of_string;
    logic               end_of_field;
    logic               error_code;
  } hpbp_token_t;

endpackage

>>> rtl/core/hpbp_if.sv
// ----------------------------------------------------------------------------
// hpbp_if: request channels of the hpack header block parser
// Octet input channel and token result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface hpbp_octet_if;
  logic       valid;
  logic       ready;
  logic [7:0] octet;

  modport source (output valid, output octet, input ready);
  modport sink (input valid, input octet, output ready);
endinterface

interface hpbp_token_if import hpbp_pkg::*;;
  logic               valid;
  logic               ready;
  logic [1:0]         token_kind;
  logic [2:0]         field_kind;
  logic [VALUE_W-1:0] number;
  logic [7:0]         string_byte;
  logic               is_value;
  logic               huffman_coded;
  logic               last_of_string;
  logic               end_of_field;
  logic               error_code;

  modport source (
    output valid, output token_kind, output field_kind, output number,
    output string_byte, output is_value, output huffman_coded,
    output last_of_string, output end_of_field, output error_code,
    input ready
  );
  modport sink (
    input valid, input token_kind, input field_kind, input number,
    input string_byte, input is_value, input huffman_coded,
    input last_of_string, input end_of_field, input error_code,
    output ready
  );
endinterface

>>> rtl/core/hpbp_front.sv
// ----------------------------------------------------------------------------
// hpbp_front: octet classifier
// Decodes each octet as a representation opener: kind and prefix integer.
// ----------------------------------------------------------------------------
module hpbp_front import hpbp_pkg::*; (
  input  logic [7:0]  octet,
  output hpbp_item_t  item
);

  logic [6:0] mask;

  always_comb begin
    if (octet[7]) begin
      item.kind = FK_INDEXED;
      mask      = 7'h7f;
    end else if (octet[6]) begin
      item.kind = FK_INC_IDX;
      mask      = 7'h3f;
    end else if (octet[5]) begin
      item.kind = FK_SIZE;
      mask      = 7'h1f;
    end else if (octet[4]) begin
      item.kind = FK_NEVER;
      mask      = 7'h0f;
    end else begin
      item.kind = FK_NO_IDX;
      mask      = 7'h0f;
    end
    item.octet       = octet;
    item.prefix_val  = octet[6:0] & mask;
    item.prefix_full = (item.prefix_val == mask);
  end

endmodule

>>> rtl/core/hpbp_queue.sv
// ----------------------------------------------------------------------------
// hpbp_queue: classified octet queue
// Short fifo between the classifier and the parser state machine.
// ----------------------------------------------------------------------------
module hpbp_queue import hpbp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  hpbp_item_t push_item,
  output logic       full,
  input  logic       pop,
  output logic       empty,
  output hpbp_item_t pop_item
);

  hpbp_item_t     mem [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   count_r, count_nxt;

  assign full     = (count_r == (QAW+1)'(QDEPTH));
  assign empty    = (count_r == '0);
  assign pop_item = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (QAW+1)'(push) - (QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> rtl/core/hpbp_back.sv
// ----------------------------------------------------------------------------
// hpbp_back: representation parser
// Walks the field and string phases, decodes prefix integers and registers
// at most one token per octet into the result stage.
// ----------------------------------------------------------------------------
module hpbp_back import hpbp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        item_valid,
  input  hpbp_item_t  item,
  output logic        item_take,
  output logic        tok_valid,
  input  logic        tok_ready,
  output hpbp_token_t tok
);

  logic [2:0]         phase_r, phase_nxt;
  logic [2:0]         kind_r, kind_nxt;
  logic [VALUE_W-1:0] acc_r, acc_nxt;
  logic [2:0]         cnt_r, cnt_nxt;
  logic [VALUE_W-1:0] rem_r, rem_nxt;
  logic               iv_r, iv_nxt;
  logic               huff_r, huff_nxt;
  logic               tok_valid_r;
  hpbp_token_t        tok_r;

  hpbp_token_t        tk;
  logic               emit;
  logic               fd_go, ld_go;
  logic [VALUE_W-1:0] fd_val, ld_val;

  // continuation octet arithmetic
  logic [7:0]         b;
  logic [5:0]         shamt;
  logic [63:0]        add_w;
  logic [VALUE_W:0]   sum;
  logic               int_ovf, int_pend;

  assign b         = item.octet;
  assign item_take = item_valid && (!tok_valid_r || tok_ready);
  assign tok_valid = tok_valid_r;
  assign tok       = tok_r;

  always_comb begin
    shamt    = {cnt_r, 3'b000} - {3'b000, cnt_r};
    add_w    = {57'd0, b[6:0]} << shamt;
    sum      = {1'b0, acc_r} + {1'b0, add_w[VALUE_W-1:0]};
    int_ovf  = (add_w[63:VALUE_W] != '0) || sum[VALUE_W] ||
               (b[7] && (cnt_r == CONT_MAX));
    int_pend = b[7];
  end

  always_comb begin
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    iv_nxt    = iv_r;
    huff_nxt  = huff_r;
    emit      = 1'b0;
    fd_go     = 1'b0;
    ld_go     = 1'b0;
    fd_val    = '0;
    ld_val    = '0;
    tk        = '0;

    case (phase_r)
      PH_FIELD_INT, PH_STR_INT: begin
        if (int_ovf) begin
          emit          = 1'b1;
          tk.token_kind = TK_ERROR;
          tk.error_code = ERR_OVERFLOW;
          phase_nxt     = PH_FIRST;
        end else if (int_pend) begin
          acc_nxt = sum[VALUE_W-1:0];
          cnt_nxt = cnt_r + 1'b1;
        end else if (phase_r == PH_FIELD_INT) begin
          fd_go  = 1'b1;
          fd_val = sum[VALUE_W-1:0];
        end else begin
          ld_go  = 1'b1;
          ld_val = sum[VALUE_W-1:0];
        end
      end
      PH_STR_HDR: begin
        huff_nxt = b[7];
        if (b[6:0] != PFX7_ONES) begin
          ld_go  = 1'b1;
          ld_val = VALUE_W'(b[6:0]);
        end else begin
          acc_nxt   = VALUE_W'(PFX7_ONES);
          cnt_nxt   = '0;
          phase_nxt = PH_STR_INT;
        end
      end
      PH_STR_BYTES: begin
        emit              = 1'b1;
        rem_nxt           = (rem_r != '0) ? rem_r - 1'b1 : rem_r;
        tk.token_kind     = TK_STR_BYTE;
        tk.string_byte    = b;
        tk.is_value       = iv_r;
        tk.huffman_coded  = huff_r;
        tk.last_of_string = (rem_nxt == '0);
        tk.end_of_field   = (rem_nxt == '0) && iv_r;
        if (rem_nxt == '0) begin
          if (iv_r) begin
            phase_nxt = PH_FIRST;
          end else begin
            iv_nxt    = 1'b1;
            phase_nxt = PH_STR_HDR;
          end
        end
      end
      default: begin
        kind_nxt = item.kind;
        if (!item.prefix_full) begin
          fd_go  = 1'b1;
          fd_val = VALUE_W'(item.prefix_val);
        end else begin
          acc_nxt   = VALUE_W'(item.prefix_val);
          cnt_nxt   = '0;
          phase_nxt = PH_FIELD_INT;
        end
      end
    endcase

    // prefix integer of a field representation complete
    if (fd_go) begin
      emit = 1'b1;
      if ((kind_nxt == FK_INDEXED) && (fd_val == '0)) begin
        tk.token_kind = TK_ERROR;
        tk.error_code = ERR_ZERO_INDEX;
        phase_nxt     = PH_FIRST;
      end else if ((kind_nxt == FK_INDEXED) || (kind_nxt == FK_SIZE)) begin
        tk.token_kind   = TK_START;
        tk.number       = fd_val;
        tk.end_of_field = 1'b1;
        phase_nxt       = PH_FIRST;
      end else begin
        tk.token_kind = TK_START;
        tk.number     = fd_val;
        iv_nxt        = (fd_val != '0);
        phase_nxt     = PH_STR_HDR;
      end
    end

    // string length complete
    if (ld_go) begin
      emit             = 1'b1;
      tk.token_kind    = TK_STR_HDR;
      tk.number        = ld_val;
      tk.is_value      = iv_r;
      tk.huffman_coded = huff_nxt;
      if (ld_val == '0) begin
        tk.last_of_string = 1'b1;
        tk.end_of_field   = iv_r;
        if (iv_r) begin
          phase_nxt = PH_FIRST;
        end else begin
          iv_nxt    = 1'b1;
          phase_nxt = PH_STR_HDR;
        end
      end else begin
        rem_nxt   = ld_val;
        phase_nxt = PH_STR_BYTES;
      end
    end

    tk.field_kind = kind_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_FIRST;
      kind_r      <= FK_INDEXED;
      acc_r       <= '0;
      cnt_r       <= '0;
      rem_r       <= '0;
      iv_r        <= 1'b0;
      huff_r      <= 1'b0;
      tok_valid_r <= 1'b0;
    end else begin
      if (item_take) begin
        phase_r     <= phase_nxt;
        kind_r      <= kind_nxt;
        acc_r       <= acc_nxt;
        cnt_r       <= cnt_nxt;
        rem_r       <= rem_nxt;
        iv_r        <= iv_nxt;
        huff_r      <= huff_nxt;
        tok_valid_r <= emit;
      end else if (tok_ready) begin
        tok_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take && emit) begin
      tok_r <= tk;
    end
  end

endmodule

>>> rtl/core/hpack_header_block_parser_unit.sv
// ----------------------------------------------------------------------------
// hpack_header_block_parser_unit: hpack header block parser
// Turns header block octets into field start, string and error tokens.
// ----------------------------------------------------------------------------
// path: an accepted octet is written into the queue, and any token it yields is registered in the token register
// throughput: one octet per cycle while the token output is not stalled
// a four-entry queue lets input continue while the result side stalls
// reset: synchronous active-low rst_n empties the queue and returns the parser
// to expecting the first octet of a representation
module hpack_header_block_parser_unit import hpbp_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  hpbp_octet_if.sink    in_ch,
  hpbp_token_if.source  out_ch
);

  hpbp_item_t  front_item;
  hpbp_item_t  q_item;
  logic        q_full, q_empty, q_pop;
  hpbp_token_t tok;

  assign in_ch.ready = !q_full;

  hpbp_front u_front (
    .octet (in_ch.octet),
    .item  (front_item)
  );

  hpbp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_ch.valid && !q_full),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_item  (q_item)
  );

  hpbp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (!q_empty),
    .item       (q_item),
    .item_take  (q_pop),
    .tok_valid  (out_ch.valid),
    .tok_ready  (out_ch.ready),
    .tok        (tok)
  );

  assign out_ch.token_kind     = tok.token_kind;
  assign out_ch.field_kind     = tok.field_kind;
  assign out_ch.number         = tok.number;
  assign out_ch.string_byte    = tok.string_byte;
  assign out_ch.is_value       = tok.is_value;
  assign out_ch.huffman_coded  = tok.huffman_coded;
  assign out_ch.last_of_string = tok.last_of_string;
  assign out_ch.end_of_field   = tok.end_of_field;
  assign out_ch.error_code     = tok.error_code;

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("parser took an item from an empty queue");

  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !q_empty)
    else $error("accepted octet missing from queue");

  a_error_number: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.token_kind == TK_ERROR)) |->
      ((out_ch.number == '0) && !out_ch.end_of_field))
    else $error("error token carries a number or end of field");

endmodule
